// ===== rtl/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// Types, codes and reset constants shared by the launcher firing sequencer.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int TIMER_BITS_DEF  = 24;
  localparam int BRAKE_OFFSET_US = 300;
  localparam int CFG_AW          = 5;
  localparam int CFG_DW          = 32;
  localparam int POWER_MAX       = 100;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'd0,
    MODE_ARMING    = 4'd1,
    MODE_ARMED     = 4'd2,
    MODE_DISARMING = 4'd3,
    MODE_DISARMED  = 4'd4,
    MODE_SPINUP    = 4'd5,
    MODE_PUSH      = 4'd6,
    MODE_BRAKE     = 4'd7,
    MODE_COOLDOWN  = 4'd8,
    MODE_ESCTEST   = 4'd9,
    MODE_CALIB     = 4'd10
  } mode_e;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_ARM      = 3'd1,
    FUNC_DISARM   = 3'd2,
    FUNC_FIRE     = 3'd3,
    FUNC_BRAKE    = 3'd4,
    FUNC_ESCTEST  = 3'd5,
    FUNC_CALIB    = 3'd6,
    FUNC_ACTIVITY = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_ARMED = 2'd1,
    ERR_NOT_PUSH  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    REG_SHOT_DURATION = 3'd0,
    REG_SERVO_NEUTRAL = 3'd1,
    REG_PUSH_OFFSET   = 3'd2,
    REG_SPINUP        = 3'd3,
    REG_BRAKE         = 3'd4,
    REG_COOLDOWN      = 3'd5,
    REG_AUTO_DISARM   = 3'd6,
    REG_ARM_DELAY     = 3'd7
  } reg_idx_e;

  localparam logic [15:0] RST_SHOT_DURATION = 16'd150;
  localparam logic [11:0] RST_SERVO_NEUTRAL = 12'd1500;
  localparam logic [10:0] RST_PUSH_OFFSET   = 11'd500;
  localparam logic [15:0] RST_SPINUP        = 16'd200;
  localparam logic [15:0] RST_BRAKE         = 16'd100;
  localparam logic [15:0] RST_COOLDOWN      = 16'd300;
  localparam logic [23:0] RST_AUTO_DISARM   = 24'd60000;
  localparam logic [15:0] RST_ARM_DELAY     = 16'd1000;

  typedef struct packed {
    logic [15:0] shot_duration_ms;
    logic [11:0] servo_neutral_us;
    logic [10:0] push_offset_us;
    logic [15:0] spin_time_ms;
    logic [15:0] brake_time_ms;
    logic [15:0] cooldown_ms;
    logic [23:0] idle_disarm_ms;
    logic [15:0] arm_wait_ms;
  } cfg_t;

  // sequencer state apart from the elapsed-time counters
  typedef struct packed {
    mode_e       mode;
    mode_e       pending;
    logic [6:0]  target_power;
    logic        armed;
    logic        esc_attach;
    logic        servo_attach;
    logic [6:0]  power_out;
    logic [11:0] pulse_out;
  } seq_st_t;

endpackage

// ===== rtl/lfs_if.sv =====
// ----------------------------------------------------------------------------
// lfs_in_if / lfs_out_if
// Valid/ready channels for commands and sequencer status beats.
// ----------------------------------------------------------------------------
interface lfs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [6:0] power_percent;

  modport source (output valid, func, power_percent, input ready);
  modport sink (input valid, func, power_percent, output ready);
endinterface

interface lfs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  current_mode;
  logic        is_armed;
  logic [6:0]  flywheel_power;
  logic [11:0] servo_pulse_us;
  logic        escs_attached;
  logic        servo_attached;
  logic [1:0]  error_code;
  logic        mode_changed;

  modport source (output valid, current_mode, is_armed, flywheel_power, servo_pulse_us,
                  escs_attached, servo_attached, error_code, mode_changed,
                  input ready);
  modport sink (input valid, current_mode, is_armed, flywheel_power, servo_pulse_us,
                escs_attached, servo_attached, error_code, mode_changed,
                output ready);
endinterface

// ===== rtl/launcher_firing_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// launcher_firing_sequencer_core
// Arm, fire and disarm sequencer for a flywheel-and-servo launcher, one status
// beat for every tick or command beat.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  in_ch    | sink      | func, power_percent (tick or command)
//  out_ch   | source    | mode, armed, power, servo pulse, attach, error, change
//  apb      | slave     | eight timing/servo registers at 4*index, no wait states
//
//  the step logic sits between the state registers and the status output
//  register, so in_ch takes a beat every clock unless out_ch stalls;
//  in_ch.ready drops only while the output register is full and out_ch stalls
//  synchronous active-low reset returns idle mode, zero counters, neutral pulse
//  and the default register values
// ----------------------------------------------------------------------------
module launcher_firing_sequencer_core #(
  parameter int TIMER_BITS = lfs_pkg::TIMER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lfs_in_if.sink                      in_ch,
  lfs_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfs_pkg::CFG_AW-1:0]  paddr,
  input  logic [lfs_pkg::CFG_DW-1:0]  pwdata,
  output logic [lfs_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  lfs_pkg::cfg_t         cfg;
  lfs_pkg::seq_st_t      st_r, st_nxt;
  logic [TIMER_BITS-1:0] mode_ms_r, mode_ms_nxt;
  logic [TIMER_BITS-1:0] idle_ms_r, idle_ms_nxt;
  lfs_pkg::err_e         err;
  logic                  changed;
  logic                  out_valid_r;
  logic                  in_fire;

  // output beat register
  logic [3:0]            mode_out_r;
  logic                  armed_out_r;
  logic [6:0]            power_out_r;
  logic [11:0]           pulse_out_r;
  logic                  esc_out_r;
  logic                  servo_out_r;
  logic [1:0]            err_out_r;
  logic                  changed_out_r;

  lfs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfs_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .func          (in_ch.func),
    .power_percent (in_ch.power_percent),
    .cfg           (cfg),
    .st            (st_r),
    .mode_ms       (mode_ms_r),
    .idle_ms       (idle_ms_r),
    .st_nxt        (st_nxt),
    .mode_ms_nxt   (mode_ms_nxt),
    .idle_ms_nxt   (idle_ms_nxt),
    .err           (err),
    .changed       (changed)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode         <= lfs_pkg::MODE_IDLE;
      st_r.pending      <= lfs_pkg::MODE_IDLE;
      st_r.target_power <= '0;
      st_r.armed        <= 1'b0;
      st_r.esc_attach   <= 1'b0;
      st_r.servo_attach <= 1'b0;
      st_r.power_out    <= '0;
      st_r.pulse_out    <= lfs_pkg::RST_SERVO_NEUTRAL;
      mode_ms_r         <= '0;
      idle_ms_r         <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        mode_ms_r   <= mode_ms_nxt;
        idle_ms_r   <= idle_ms_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_out_r    <= st_nxt.mode;
      armed_out_r   <= st_nxt.armed;
      power_out_r   <= st_nxt.power_out;
      pulse_out_r   <= st_nxt.pulse_out;
      esc_out_r     <= st_nxt.esc_attach;
      servo_out_r   <= st_nxt.servo_attach;
      err_out_r     <= err;
      changed_out_r <= changed;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.current_mode   = mode_out_r;
  assign out_ch.is_armed       = armed_out_r;
  assign out_ch.flywheel_power = power_out_r;
  assign out_ch.servo_pulse_us = pulse_out_r;
  assign out_ch.escs_attached  = esc_out_r;
  assign out_ch.servo_attached = servo_out_r;
  assign out_ch.error_code     = err_out_r;
  assign out_ch.mode_changed   = changed_out_r;

  // armed is only ever set together with the esc attach
  a_armed_attached: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.armed |-> st_r.esc_attach)
    else $error("armed without escs attached");

  // every accepted beat shows up on the output
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat produced no status beat");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.power_out <= 7'(lfs_pkg::POWER_MAX)) &&
    (st_r.target_power <= 7'(lfs_pkg::POWER_MAX)))
    else $error("flywheel power above limit");

  // the counter restarts on every mode entry apart from calib and idle
  a_mode_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (st_nxt.mode != st_r.mode) && (st_nxt.mode != lfs_pkg::MODE_CALIB) &&
     (st_nxt.mode != lfs_pkg::MODE_IDLE)) |=> (mode_ms_r == '0))
    else $error("mode entered without timer restart");

endmodule

// ===== rtl/lfs_cfg.sv =====
// ----------------------------------------------------------------------------
// lfs_cfg
// APB-style register file holding the sequencer timing and servo settings.
// ----------------------------------------------------------------------------
module lfs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfs_pkg::CFG_AW-1:0]  paddr,
  input  logic [lfs_pkg::CFG_DW-1:0]  pwdata,
  output logic [lfs_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output lfs_pkg::cfg_t               cfg
);

  lfs_pkg::cfg_t     cfg_r;
  lfs_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = lfs_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shot_duration_ms <= lfs_pkg::RST_SHOT_DURATION;
      cfg_r.servo_neutral_us <= lfs_pkg::RST_SERVO_NEUTRAL;
      cfg_r.push_offset_us   <= lfs_pkg::RST_PUSH_OFFSET;
      cfg_r.spin_time_ms     <= lfs_pkg::RST_SPINUP;
      cfg_r.brake_time_ms    <= lfs_pkg::RST_BRAKE;
      cfg_r.cooldown_ms      <= lfs_pkg::RST_COOLDOWN;
      cfg_r.idle_disarm_ms   <= lfs_pkg::RST_AUTO_DISARM;
      cfg_r.arm_wait_ms      <= lfs_pkg::RST_ARM_DELAY;
    end else if (wr_en) begin
      unique case (idx)
        lfs_pkg::REG_SHOT_DURATION: cfg_r.shot_duration_ms <= pwdata[15:0];
        lfs_pkg::REG_SERVO_NEUTRAL: cfg_r.servo_neutral_us <= pwdata[11:0];
        lfs_pkg::REG_PUSH_OFFSET:   cfg_r.push_offset_us   <= pwdata[10:0];
        lfs_pkg::REG_SPINUP:        cfg_r.spin_time_ms     <= pwdata[15:0];
        lfs_pkg::REG_BRAKE:         cfg_r.brake_time_ms    <= pwdata[15:0];
        lfs_pkg::REG_COOLDOWN:      cfg_r.cooldown_ms      <= pwdata[15:0];
        lfs_pkg::REG_AUTO_DISARM:   cfg_r.idle_disarm_ms   <= pwdata[23:0];
        lfs_pkg::REG_ARM_DELAY:     cfg_r.arm_wait_ms      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lfs_pkg::REG_SHOT_DURATION: prdata = 32'(cfg_r.shot_duration_ms);
      lfs_pkg::REG_SERVO_NEUTRAL: prdata = 32'(cfg_r.servo_neutral_us);
      lfs_pkg::REG_PUSH_OFFSET:   prdata = 32'(cfg_r.push_offset_us);
      lfs_pkg::REG_SPINUP:        prdata = 32'(cfg_r.spin_time_ms);
      lfs_pkg::REG_BRAKE:         prdata = 32'(cfg_r.brake_time_ms);
      lfs_pkg::REG_COOLDOWN:      prdata = 32'(cfg_r.cooldown_ms);
      lfs_pkg::REG_AUTO_DISARM:   prdata = 32'(cfg_r.idle_disarm_ms);
      lfs_pkg::REG_ARM_DELAY:     prdata = 32'(cfg_r.arm_wait_ms);
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/lfs_step.sv =====
// ----------------------------------------------------------------------------
// lfs_step
// Next-state logic for one tick or command: counters, timed transitions,
// command handling and mode entry actions.
// ----------------------------------------------------------------------------
module lfs_step #(
  parameter int TIMER_BITS = lfs_pkg::TIMER_BITS_DEF
) (
  input  logic [2:0]             func,
  input  logic [6:0]             power_percent,
  input  lfs_pkg::cfg_t          cfg,
  input  lfs_pkg::seq_st_t       st,
  input  logic [TIMER_BITS-1:0]  mode_ms,
  input  logic [TIMER_BITS-1:0]  idle_ms,
  output lfs_pkg::seq_st_t       st_nxt,
  output logic [TIMER_BITS-1:0]  mode_ms_nxt,
  output logic [TIMER_BITS-1:0]  idle_ms_nxt,
  output lfs_pkg::err_e          err,
  output logic                   changed
);

  localparam int CMP_W = (TIMER_BITS > 24) ? TIMER_BITS : 24;

  logic [TIMER_BITS-1:0] mode_inc;
  logic [TIMER_BITS-1:0] idle_inc;
  logic [CMP_W-1:0]      mode_cmp;
  logic [CMP_W-1:0]      idle_cmp;
  logic [12:0]           push_sum;
  logic [11:0]           push_pulse;
  logic [11:0]           brake_pulse;
  logic [6:0]            power_sat;
  lfs_pkg::func_e        fn;
  lfs_pkg::mode_e        pend;

  assign fn       = lfs_pkg::func_e'(func);
  assign mode_inc = (&mode_ms) ? mode_ms : mode_ms + 1'b1;
  assign idle_inc = (&idle_ms) ? idle_ms : idle_ms + 1'b1;
  assign mode_cmp = CMP_W'(mode_inc);
  assign idle_cmp = CMP_W'(idle_inc);

  assign push_sum    = {1'b0, cfg.servo_neutral_us} + {2'b00, cfg.push_offset_us};
  assign push_pulse  = push_sum[12] ? 12'hFFF : push_sum[11:0];
  assign brake_pulse = (cfg.servo_neutral_us >= 12'(lfs_pkg::BRAKE_OFFSET_US)) ?
                       cfg.servo_neutral_us - 12'(lfs_pkg::BRAKE_OFFSET_US) : 12'd0;
  assign power_sat   = (power_percent > 7'(lfs_pkg::POWER_MAX)) ?
                       7'(lfs_pkg::POWER_MAX) : power_percent;

  always_comb begin
    st_nxt      = st;
    mode_ms_nxt = mode_ms;
    idle_ms_nxt = idle_ms;
    err         = lfs_pkg::ERR_NONE;
    changed     = 1'b0;
    pend        = st.pending;

    case (fn)
      lfs_pkg::FUNC_TICK: begin
        mode_ms_nxt = mode_inc;
        idle_ms_nxt = idle_inc;
        // timed transitions only when no command request is outstanding
        if (st.pending == st.mode) begin
          unique case (st.mode)
            lfs_pkg::MODE_ARMING:
              if (mode_cmp >= CMP_W'(cfg.arm_wait_ms)) pend = lfs_pkg::MODE_ARMED;
            lfs_pkg::MODE_ARMED:
              if (idle_cmp >= CMP_W'(cfg.idle_disarm_ms)) pend = lfs_pkg::MODE_DISARMING;
            lfs_pkg::MODE_DISARMING:
              pend = lfs_pkg::MODE_DISARMED;
            lfs_pkg::MODE_SPINUP:
              if (mode_cmp >= CMP_W'(cfg.spin_time_ms)) pend = lfs_pkg::MODE_PUSH;
            lfs_pkg::MODE_PUSH:
              if (mode_cmp >= CMP_W'(cfg.shot_duration_ms)) pend = lfs_pkg::MODE_COOLDOWN;
            lfs_pkg::MODE_BRAKE:
              if (mode_cmp >= CMP_W'(cfg.brake_time_ms)) pend = lfs_pkg::MODE_COOLDOWN;
            lfs_pkg::MODE_COOLDOWN:
              if (mode_cmp >= CMP_W'(cfg.cooldown_ms)) pend = lfs_pkg::MODE_ARMED;
            default: ;
          endcase
        end
        st_nxt.pending = pend;
        if (pend != st.mode) begin
          st_nxt.mode = pend;
          mode_ms_nxt = '0;
          changed     = 1'b1;
          // entry actions
          unique case (pend)
            lfs_pkg::MODE_ARMED: begin
              st_nxt.esc_attach = 1'b1;
              st_nxt.armed      = 1'b1;
              if (st.mode == lfs_pkg::MODE_COOLDOWN) st_nxt.servo_attach = 1'b0;
            end
            lfs_pkg::MODE_DISARMING: st_nxt.armed = 1'b0;
            lfs_pkg::MODE_DISARMED: begin
              st_nxt.esc_attach   = 1'b0;
              st_nxt.servo_attach = 1'b0;
            end
            lfs_pkg::MODE_SPINUP, lfs_pkg::MODE_ESCTEST:
              st_nxt.power_out = st.target_power;
            lfs_pkg::MODE_PUSH: begin
              st_nxt.servo_attach = 1'b1;
              st_nxt.pulse_out    = push_pulse;
            end
            lfs_pkg::MODE_BRAKE: st_nxt.pulse_out = brake_pulse;
            lfs_pkg::MODE_COOLDOWN: begin
              st_nxt.pulse_out = cfg.servo_neutral_us;
              st_nxt.power_out = '0;
            end
            default: ;
          endcase
        end
      end
      lfs_pkg::FUNC_ARM: begin
        idle_ms_nxt = '0;
        if (!st.armed && (st.mode == lfs_pkg::MODE_IDLE ||
                          st.mode == lfs_pkg::MODE_DISARMED)) begin
          st_nxt.pending = lfs_pkg::MODE_ARMING;
          mode_ms_nxt    = '0;
        end
      end
      lfs_pkg::FUNC_DISARM: begin
        if (st.mode == lfs_pkg::MODE_CALIB) begin
          st_nxt.esc_attach   = 1'b0;
          st_nxt.servo_attach = 1'b0;
          st_nxt.armed        = 1'b0;
          st_nxt.mode         = lfs_pkg::MODE_IDLE;
          st_nxt.pending      = lfs_pkg::MODE_IDLE;
          changed             = 1'b1;
        end else begin
          st_nxt.pending = lfs_pkg::MODE_DISARMING;
          mode_ms_nxt    = '0;
        end
      end
      lfs_pkg::FUNC_FIRE: begin
        if (!st.armed) begin
          err = lfs_pkg::ERR_NOT_ARMED;
        end else if (st.mode == lfs_pkg::MODE_ARMED) begin
          st_nxt.target_power = power_sat;
          st_nxt.pending      = lfs_pkg::MODE_SPINUP;
          mode_ms_nxt         = '0;
          idle_ms_nxt         = '0;
        end
      end
      lfs_pkg::FUNC_BRAKE: begin
        if (st.mode != lfs_pkg::MODE_PUSH) begin
          err = lfs_pkg::ERR_NOT_PUSH;
        end else begin
          st_nxt.pending = lfs_pkg::MODE_BRAKE;
          mode_ms_nxt    = '0;
        end
      end
      lfs_pkg::FUNC_ESCTEST: begin
        if (!st.armed) begin
          err = lfs_pkg::ERR_NOT_ARMED;
        end else begin
          st_nxt.target_power = power_sat;
          st_nxt.pending      = lfs_pkg::MODE_ESCTEST;
          mode_ms_nxt         = '0;
          idle_ms_nxt         = '0;
        end
      end
      lfs_pkg::FUNC_CALIB: begin
        if (!st.armed) begin
          err = lfs_pkg::ERR_NOT_ARMED;
        end else begin
          st_nxt.esc_attach = 1'b1;
          changed           = (st.mode != lfs_pkg::MODE_CALIB);
          st_nxt.mode       = lfs_pkg::MODE_CALIB;
          st_nxt.pending    = lfs_pkg::MODE_CALIB;
        end
      end
      default: idle_ms_nxt = '0;
    endcase
  end

endmodule

// ===== tb/sv/launcher_firing_sequencer_core_test.sv =====
// ----------------------------------------------------------------------------
// launcher_firing_sequencer_core_test
// Drives tick and command beats into the sequencer under random valid/ready
// gaps, and compares every status beat against a cycle-free model of the arm,
// fire, brake, cooldown and disarm timing kept in this module. The APB port
// loads several timing and servo settings between phases, the extremes among
// them. The timer is built at a width of 16 bits.
// ----------------------------------------------------------------------------
module launcher_firing_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TIMER_W     = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [TIMER_W-1:0] MS_MAX = '1;

  typedef struct packed {
    lfs_pkg::mode_e mode;
    logic           armed;
    logic [6:0]     power;
    logic [11:0]    pulse;
    logic           esc_attach;
    logic           servo_attach;
    lfs_pkg::err_e  err;
    logic           changed;
  } status_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lfs_pkg::CFG_AW-1:0] paddr;
  logic [lfs_pkg::CFG_DW-1:0] pwdata;
  logic [lfs_pkg::CFG_DW-1:0] prdata;
  logic pready;

  lfs_in_if  in_ch();
  lfs_out_if out_ch();

  launcher_firing_sequencer_core #(.TIMER_BITS(TIMER_W)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model state, settings at their reset values
  lfs_pkg::cfg_t cfg = '{
    shot_duration_ms: lfs_pkg::RST_SHOT_DURATION,
    servo_neutral_us: lfs_pkg::RST_SERVO_NEUTRAL,
    push_offset_us:   lfs_pkg::RST_PUSH_OFFSET,
    spin_time_ms:     lfs_pkg::RST_SPINUP,
    brake_time_ms:    lfs_pkg::RST_BRAKE,
    cooldown_ms:      lfs_pkg::RST_COOLDOWN,
    idle_disarm_ms:   lfs_pkg::RST_AUTO_DISARM,
    arm_wait_ms:      lfs_pkg::RST_ARM_DELAY
  };
  lfs_pkg::seq_st_t sq = '{
    mode:         lfs_pkg::MODE_IDLE,
    pending:      lfs_pkg::MODE_IDLE,
    target_power: 7'd0,
    armed:        1'b0,
    esc_attach:   1'b0,
    servo_attach: 1'b0,
    power_out:    7'd0,
    pulse_out:    lfs_pkg::RST_SERVO_NEUTRAL
  };
  logic [TIMER_W-1:0] mode_ms  = '0;
  logic [TIMER_W-1:0] quiet_ms = '0;

  status_t     expected_status[$];
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold     = 0;
  bit          tx_gaps     = 1'b0;
  bit          rx_gaps     = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [TIMER_W-1:0] bump_ms(logic [TIMER_W-1:0] v);
    return (v == MS_MAX) ? v : v + 1'b1;
  endfunction

  // one tick or command against the model, returns the status beat it causes
  function automatic status_t advance_sequencer(lfs_pkg::func_e f, logic [6:0] pct);
    status_t        s;
    lfs_pkg::mode_e prev;
    logic [12:0]    push_sum;
    logic [6:0]     want_power;
    lfs_pkg::err_e  err;
    logic           changed;
    err        = lfs_pkg::ERR_NONE;
    changed    = 1'b0;
    want_power = (pct > 7'(lfs_pkg::POWER_MAX)) ? 7'(lfs_pkg::POWER_MAX) : pct;
    case (f)
      lfs_pkg::FUNC_TICK: begin
        mode_ms  = bump_ms(mode_ms);
        quiet_ms = bump_ms(quiet_ms);
        // timed exits apply only when no command is waiting
        if (sq.pending == sq.mode) begin
          case (sq.mode)
            lfs_pkg::MODE_ARMING:
              if (mode_ms >= cfg.arm_wait_ms) sq.pending = lfs_pkg::MODE_ARMED;
            lfs_pkg::MODE_ARMED:
              if (quiet_ms >= cfg.idle_disarm_ms) sq.pending = lfs_pkg::MODE_DISARMING;
            lfs_pkg::MODE_DISARMING:
              sq.pending = lfs_pkg::MODE_DISARMED;
            lfs_pkg::MODE_SPINUP:
              if (mode_ms >= cfg.spin_time_ms) sq.pending = lfs_pkg::MODE_PUSH;
            lfs_pkg::MODE_PUSH:
              if (mode_ms >= cfg.shot_duration_ms) sq.pending = lfs_pkg::MODE_COOLDOWN;
            lfs_pkg::MODE_BRAKE:
              if (mode_ms >= cfg.brake_time_ms) sq.pending = lfs_pkg::MODE_COOLDOWN;
            lfs_pkg::MODE_COOLDOWN:
              if (mode_ms >= cfg.cooldown_ms) sq.pending = lfs_pkg::MODE_ARMED;
            default: ;
          endcase
        end
        if (sq.pending != sq.mode) begin
          prev    = sq.mode;
          sq.mode = sq.pending;
          mode_ms = '0;
          changed = 1'b1;
          case (sq.mode)
            lfs_pkg::MODE_ARMED: begin
              sq.esc_attach = 1'b1;
              sq.armed      = 1'b1;
              if (prev == lfs_pkg::MODE_COOLDOWN) sq.servo_attach = 1'b0;
            end
            lfs_pkg::MODE_DISARMING: sq.armed = 1'b0;
            lfs_pkg::MODE_DISARMED: begin
              sq.esc_attach   = 1'b0;
              sq.servo_attach = 1'b0;
            end
            lfs_pkg::MODE_SPINUP, lfs_pkg::MODE_ESCTEST: sq.power_out = sq.target_power;
            lfs_pkg::MODE_PUSH: begin
              sq.servo_attach = 1'b1;
              push_sum = 13'(cfg.servo_neutral_us) + 13'(cfg.push_offset_us);
              sq.pulse_out = (push_sum > 13'd4095) ? 12'd4095 : push_sum[11:0];
            end
            lfs_pkg::MODE_BRAKE: begin
              sq.pulse_out = (cfg.servo_neutral_us >= 12'(lfs_pkg::BRAKE_OFFSET_US)) ?
                             cfg.servo_neutral_us - 12'(lfs_pkg::BRAKE_OFFSET_US) : 12'd0;
            end
            lfs_pkg::MODE_COOLDOWN: begin
              sq.pulse_out = cfg.servo_neutral_us;
              sq.power_out = 7'd0;
            end
            default: ;
          endcase
        end
      end
      lfs_pkg::FUNC_ARM: begin
        quiet_ms = '0;
        if (!sq.armed && (sq.mode == lfs_pkg::MODE_IDLE ||
                          sq.mode == lfs_pkg::MODE_DISARMED)) begin
          sq.pending = lfs_pkg::MODE_ARMING;
          mode_ms    = '0;
        end
      end
      lfs_pkg::FUNC_DISARM: begin
        if (sq.mode == lfs_pkg::MODE_CALIB) begin
          sq.esc_attach   = 1'b0;
          sq.servo_attach = 1'b0;
          sq.armed        = 1'b0;
          sq.mode         = lfs_pkg::MODE_IDLE;
          sq.pending      = lfs_pkg::MODE_IDLE;
          changed         = 1'b1;
        end else begin
          sq.pending = lfs_pkg::MODE_DISARMING;
          mode_ms    = '0;
        end
      end
      lfs_pkg::FUNC_FIRE: begin
        if (!sq.armed) begin
          err = lfs_pkg::ERR_NOT_ARMED;
        end else if (sq.mode == lfs_pkg::MODE_ARMED) begin
          sq.target_power = want_power;
          sq.pending      = lfs_pkg::MODE_SPINUP;
          mode_ms         = '0;
          quiet_ms        = '0;
        end
      end
      lfs_pkg::FUNC_BRAKE: begin
        if (sq.mode != lfs_pkg::MODE_PUSH) begin
          err = lfs_pkg::ERR_NOT_PUSH;
        end else begin
          sq.pending = lfs_pkg::MODE_BRAKE;
          mode_ms    = '0;
        end
      end
      lfs_pkg::FUNC_ESCTEST: begin
        if (!sq.armed) begin
          err = lfs_pkg::ERR_NOT_ARMED;
        end else begin
          sq.target_power = want_power;
          sq.pending      = lfs_pkg::MODE_ESCTEST;
          mode_ms         = '0;
          quiet_ms        = '0;
        end
      end
      lfs_pkg::FUNC_CALIB: begin
        if (!sq.armed) begin
          err = lfs_pkg::ERR_NOT_ARMED;
        end else begin
          sq.esc_attach = 1'b1;
          changed       = (sq.mode != lfs_pkg::MODE_CALIB);
          sq.mode       = lfs_pkg::MODE_CALIB;
          sq.pending    = lfs_pkg::MODE_CALIB;
        end
      end
      default: quiet_ms = '0;
    endcase
    s.mode         = sq.mode;
    s.armed        = sq.armed;
    s.power        = sq.power_out;
    s.pulse        = sq.pulse_out;
    s.esc_attach   = sq.esc_attach;
    s.servo_attach = sq.servo_attach;
    s.err          = err;
    s.changed      = changed;
    return s;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // predict on the input beat first, then check the output beat
  always @(posedge clk) begin : scoreboard
    status_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_status.push_back(advance_sequencer(lfs_pkg::func_e'(in_ch.func),
                                                  in_ch.power_percent));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t: status beat with none expected, actual mode %0d", $time,
                 out_ch.current_mode);
        error_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("current_mode", want.mode, out_ch.current_mode);
        check_field("is_armed", want.armed, out_ch.is_armed);
        check_field("flywheel_power", want.power, out_ch.flywheel_power);
        check_field("servo_pulse_us", want.pulse, out_ch.servo_pulse_us);
        check_field("escs_attached", want.esc_attach, out_ch.escs_attached);
        check_field("servo_attached", want.servo_attach, out_ch.servo_attached);
        check_field("error_code", want.err, out_ch.error_code);
        check_field("mode_changed", want.changed, out_ch.mode_changed);
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rx_gaps && rx_hold == 0 && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 14);
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_beat(lfs_pkg::func_e f, logic [6:0] pct);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= f;
    in_ch.power_percent <= pct;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_ticks(int unsigned n);
    lfs_pkg::func_e f;
    repeat (n) begin
      f = ($urandom_range(0, 9) == 0) ? lfs_pkg::FUNC_ACTIVITY : lfs_pkg::FUNC_TICK;
      send_beat(f, 7'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(lfs_pkg::reg_idx_e idx, logic [lfs_pkg::CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lfs_pkg::REG_SHOT_DURATION: cfg.shot_duration_ms = val[15:0];
      lfs_pkg::REG_SERVO_NEUTRAL: cfg.servo_neutral_us = val[11:0];
      lfs_pkg::REG_PUSH_OFFSET:   cfg.push_offset_us   = val[10:0];
      lfs_pkg::REG_SPINUP:        cfg.spin_time_ms     = val[15:0];
      lfs_pkg::REG_BRAKE:         cfg.brake_time_ms    = val[15:0];
      lfs_pkg::REG_COOLDOWN:      cfg.cooldown_ms      = val[15:0];
      lfs_pkg::REG_AUTO_DISARM:   cfg.idle_disarm_ms   = val[23:0];
      default:                    cfg.arm_wait_ms      = val[15:0];
    endcase
  endtask

  // unused upper bits carry noise, the registers keep their own width
  task automatic load_settings(lfs_pkg::cfg_t c);
    wait_drained();
    repeat (2) @(posedge clk);
    write_setting(lfs_pkg::REG_SHOT_DURATION, {16'($urandom), c.shot_duration_ms});
    write_setting(lfs_pkg::REG_SERVO_NEUTRAL, {20'($urandom), c.servo_neutral_us});
    write_setting(lfs_pkg::REG_PUSH_OFFSET,   {21'($urandom), c.push_offset_us});
    write_setting(lfs_pkg::REG_SPINUP,        {16'($urandom), c.spin_time_ms});
    write_setting(lfs_pkg::REG_BRAKE,         {16'($urandom), c.brake_time_ms});
    write_setting(lfs_pkg::REG_COOLDOWN,      {16'($urandom), c.cooldown_ms});
    write_setting(lfs_pkg::REG_AUTO_DISARM,   {8'($urandom), c.idle_disarm_ms});
    write_setting(lfs_pkg::REG_ARM_DELAY,     {16'($urandom), c.arm_wait_ms});
  endtask

  function automatic lfs_pkg::cfg_t pick_settings(int unsigned ms_hi);
    lfs_pkg::cfg_t c;
    c.shot_duration_ms = 16'($urandom_range(0, ms_hi));
    c.servo_neutral_us = 12'($urandom_range(0, 4095));
    c.push_offset_us   = 11'($urandom_range(0, 2047));
    c.spin_time_ms     = 16'($urandom_range(0, ms_hi));
    c.brake_time_ms    = 16'($urandom_range(0, ms_hi));
    c.cooldown_ms      = 16'($urandom_range(0, ms_hi));
    c.idle_disarm_ms   = 24'($urandom_range(0, 6 * ms_hi));
    c.arm_wait_ms      = 16'($urandom_range(0, ms_hi));
    return c;
  endfunction

  function automatic logic [6:0] pick_power();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd101;
      3:       return 7'd127;
      default: return 7'($urandom);
    endcase
  endfunction

  // mostly arm and shot sequences with random timing, some loose commands
  task automatic run_mixed(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if (tx_gaps && $urandom_range(0, 39) == 0) wait_drained();
      case ($urandom_range(0, 9))
        0, 1: send_beat(lfs_pkg::func_e'($urandom_range(0, 7)), 7'($urandom));
        2, 3: begin
          send_beat(lfs_pkg::FUNC_ARM, 7'($urandom));
          send_ticks($urandom_range(0, 10));
        end
        4, 5, 6: begin
          send_beat(lfs_pkg::FUNC_FIRE, pick_power());
          send_ticks($urandom_range(0, 8));
          if ($urandom_range(0, 2) == 0) send_beat(lfs_pkg::FUNC_BRAKE, 7'($urandom));
          send_ticks($urandom_range(0, 8));
        end
        7: begin
          send_beat(lfs_pkg::FUNC_ESCTEST, pick_power());
          send_ticks($urandom_range(0, 4));
          case ($urandom_range(0, 2))
            0:       send_beat(lfs_pkg::FUNC_DISARM, 7'($urandom));
            1:       send_beat(lfs_pkg::FUNC_CALIB, 7'($urandom));
            default: send_beat(lfs_pkg::FUNC_FIRE, pick_power());
          endcase
        end
        8: begin
          send_beat(lfs_pkg::FUNC_CALIB, 7'($urandom));
          send_ticks($urandom_range(0, 3));
          if ($urandom_range(0, 1) == 0) send_beat(lfs_pkg::FUNC_DISARM, 7'($urandom));
        end
        default: begin
          send_beat(lfs_pkg::FUNC_DISARM, 7'($urandom));
          send_ticks($urandom_range(1, 3));
        end
      endcase
    end
  endtask

  // commands refused while not armed and brake outside push, then disarm from idle
  task automatic test_refused_commands();
    send_beat(lfs_pkg::FUNC_FIRE, 7'd127);
    send_beat(lfs_pkg::FUNC_ESCTEST, 7'd0);
    send_beat(lfs_pkg::FUNC_CALIB, 7'd85);
    send_beat(lfs_pkg::FUNC_BRAKE, 7'd42);
    send_beat(lfs_pkg::FUNC_ACTIVITY, 7'd1);
    send_beat(lfs_pkg::FUNC_TICK, 7'd64);
    send_beat(lfs_pkg::FUNC_DISARM, 7'd0);
    send_beat(lfs_pkg::FUNC_TICK, 7'd0);
    send_beat(lfs_pkg::FUNC_TICK, 7'd127);
    send_beat(lfs_pkg::FUNC_FIRE, 7'd100);
  endtask

  // full shot with brake, esc test, calibration, disarm and auto-disarm
  task automatic test_fire_sequence();
    lfs_pkg::cfg_t c;
    c = '{shot_duration_ms: 16'd2, servo_neutral_us: 12'd1500, push_offset_us: 11'd500,
          spin_time_ms: 16'd1, brake_time_ms: 16'd1, cooldown_ms: 16'd1,
          idle_disarm_ms: 24'd3, arm_wait_ms: 16'd1};
    load_settings(c);
    send_beat(lfs_pkg::FUNC_ARM, 7'd0);
    send_beat(lfs_pkg::FUNC_ARM, 7'd0);
    send_ticks(0);
    send_beat(lfs_pkg::FUNC_TICK, 7'd0);
    send_beat(lfs_pkg::FUNC_TICK, 7'd0);
    send_beat(lfs_pkg::FUNC_ARM, 7'd0);
    send_beat(lfs_pkg::FUNC_FIRE, 7'd127);
    send_beat(lfs_pkg::FUNC_FIRE, 7'd5);
    send_beat(lfs_pkg::FUNC_TICK, 7'd0);
    send_beat(lfs_pkg::FUNC_FIRE, 7'd3);
    send_beat(lfs_pkg::FUNC_TICK, 7'd0);
    send_beat(lfs_pkg::FUNC_BRAKE, 7'd0);
    repeat (3) send_beat(lfs_pkg::FUNC_TICK, 7'd0);
    send_beat(lfs_pkg::FUNC_ESCTEST, 7'd101);
    send_beat(lfs_pkg::FUNC_TICK, 7'd0);
    send_beat(lfs_pkg::FUNC_CALIB, 7'd0);
    send_beat(lfs_pkg::FUNC_CALIB, 7'd0);
    send_beat(lfs_pkg::FUNC_DISARM, 7'd0);
    send_beat(lfs_pkg::FUNC_ARM, 7'd0);
    repeat (5) send_beat(lfs_pkg::FUNC_TICK, 7'd0);
  endtask

  // all settings zero: immediate timed exits, brake pulse clamps at zero
  task automatic test_zero_settings();
    load_settings('0);
    run_mixed(250);
  endtask

  // push pulse clamps at the top of the range
  task automatic test_pulse_ceiling();
    lfs_pkg::cfg_t c;
    c = pick_settings(5);
    c.servo_neutral_us = 12'd4095;
    c.push_offset_us   = 11'd2047;
    load_settings(c);
    run_mixed(250);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      load_settings(pick_settings(6));
      run_mixed(250);
    end
  endtask

  // every duration at its maximum, nothing times out within the phase
  task automatic test_long_settings();
    lfs_pkg::cfg_t c;
    c = '1;
    c.servo_neutral_us = 12'($urandom);
    c.push_offset_us   = 11'($urandom);
    load_settings(c);
    run_mixed(100);
  endtask

  // last phase with no idling on either side
  task automatic test_back_to_back();
    load_settings(pick_settings(4));
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_mixed(200);
  endtask

  initial begin
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= lfs_pkg::FUNC_TICK;
    in_ch.power_percent <= 7'd0;
    repeat (2) @(posedge clk);
    rst_n   <= 1'b1;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_refused_commands();
    test_fire_sequence();
    test_zero_settings();
    test_pulse_ceiling();
    test_random_settings();
    test_long_settings();
    test_back_to_back();
    wait_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lfs_pkg.sv
rtl/lfs_if.sv
rtl/lfs_cfg.sv
rtl/lfs_step.sv
rtl/launcher_firing_sequencer_core.sv
tb/sv/launcher_firing_sequencer_core_test.sv
